### rtl/kms_pkg.sv
// Package for the keypad matrix scanner: widths, column/scan-code constants
// and the key code and character tables.
// No dependencies; used by every other file of the block.
package kms_pkg;

    // Keypad geometry
    localparam int KMS_ROWS  = 4;
    localparam int KMS_COLS  = 3;
    localparam int KMS_ROW_W = 2;
    localparam int KMS_CODE_W = KMS_ROWS + KMS_COLS;
    localparam int KMS_KEYS  = 12;

    // Configuration port
    localparam int KMS_CFG_IDX_W  = 1;
    localparam int KMS_CFG_DATA_W = 16;
    localparam logic [KMS_CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 1'b0;
    localparam logic [KMS_CFG_IDX_W-1:0] CFG_DEBOUNCE_LEN = 1'b1;

    // Register widths and reset values
    localparam int KMS_SETTLE_W = 16;
    localparam int KMS_STABLE_W = 5;
    localparam logic [KMS_SETTLE_W-1:0] SETTLE_RESET   = 16'd100;
    localparam logic [KMS_STABLE_W-1:0] DEBOUNCE_RESET = 5'd16;
    localparam logic [KMS_STABLE_W-1:0] STABLE_MAX     = 5'd31;

    // All columns pulled high means no key pulls a column low
    localparam logic [KMS_COLS-1:0]   COL_ALL_HIGH  = 3'b111;
    localparam logic [KMS_CODE_W-1:0] CODE_IDLE     = 7'h07;

    typedef logic [KMS_CODE_W-1:0] t_code;
    typedef logic [7:0]            t_char;

    // Scan code of each key, and the ASCII character it stands for
    localparam t_code KEY_CODES [KMS_KEYS] = '{
        7'h0D, 7'h46, 7'h45, 7'h43, 7'h26, 7'h25,
        7'h23, 7'h16, 7'h15, 7'h13, 7'h0E, 7'h0C
    };
    localparam t_char KEY_CHARS [KMS_KEYS] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
        8'h36, 8'h37, 8'h38, 8'h39, 8'h2A, 8'h23
    };

endpackage

### rtl/kms_in_if.sv
// Input channel of the keypad scanner: one column sample per transaction.
// Depends on kms_pkg for the column width.
interface kms_in_if;
    import kms_pkg::*;

    logic                valid;
    logic                ready;
    logic [KMS_COLS-1:0] col_levels;

    modport source (output valid, output col_levels, input ready);
    modport sink   (input valid, input col_levels, output ready);
endinterface

### rtl/kms_out_if.sv
// Output channel of the keypad scanner: row drive and key event per transaction.
// Depends on kms_pkg for the row width.
interface kms_out_if;
    import kms_pkg::*;

    logic                valid;
    logic                ready;
    logic [KMS_ROWS-1:0] row_drive;
    logic                key_valid;
    logic [7:0]          key_char;
    logic                key_unknown;

    modport source (output valid, output row_drive, output key_valid,
                    output key_char, output key_unknown, input ready);
    modport sink   (input valid, input row_drive, input key_valid,
                    input key_char, input key_unknown, output ready);
endinterface

### rtl/kms_key_lookup.sv
// Scan code to ASCII lookup for the keypad scanner.
// Depends on kms_pkg for the code and character tables.
module kms_key_lookup (
    input  kms_pkg::t_code i_code,
    output kms_pkg::t_char o_char,
    output logic           o_unknown
);
    import kms_pkg::*;

    // Compare against all table entries in parallel; codes are unique
    always_comb begin
        o_char    = '0;
        o_unknown = 1'b1;
        for (int k = 0; k < KMS_KEYS; k++) begin
            if (KEY_CODES[k] == i_code) begin
                o_char    = KEY_CHARS[k];
                o_unknown = 1'b0;
            end
        end
    end
endmodule

### rtl/keypad_matrix_scanner_unit.sv
// 4x3 matrix keypad scanner with press and release debounce.
// Depends on kms_pkg, kms_in_if, kms_out_if and kms_key_lookup.
//
// Usage:
//   i_in carries one sample of the three column pins per transaction; every
//   accepted sample yields exactly one transaction on o_out with the row
//   levels to drive from then on and, when a press has been resolved after
//   release, key_valid with the ASCII key (or key_unknown).
//   The configuration port writes settle_ticks (index 0) and debounce_len
//   (index 1, low five bits) on any edge with i_cfg_we high; write only
//   while no transaction is in flight.
// Throughput:
//   One sample per cycle sustained while o_out.ready is high. The per-sample
//   state update sits between the input handshake and the output register.
// Reset:
//   Synchronous, active low. Settle time returns to 100 ticks, debounce to
//   16 samples, the scanner goes idle with all rows low, output empty.
// Stall:
//   While the output register holds an untaken result, i_in.ready is low
//   unless o_out.ready takes that result in the same cycle.
module keypad_matrix_scanner_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    kms_in_if.sink                               i_in,
    kms_out_if.source                            o_out,
    input  logic                                 i_cfg_we,
    input  logic [kms_pkg::KMS_CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kms_pkg::KMS_CFG_DATA_W-1:0]   i_cfg_wdata
);
    import kms_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_SCAN    = 2'd1,
        MODE_RELEASE = 2'd2
    } t_mode_e;

    // Configuration registers
    logic [KMS_SETTLE_W-1:0] r_settle_ticks;
    logic [KMS_STABLE_W-1:0] r_debounce_len;

    // Scanner state
    t_mode_e                 r_mode, n_mode;
    logic [KMS_STABLE_W-1:0] r_stable, n_stable;
    logic [KMS_ROW_W-1:0]    r_row, n_row;
    logic [KMS_SETTLE_W-1:0] r_settle, n_settle;
    t_code                   r_code, n_code;

    // Output register
    logic                r_out_valid;
    logic [KMS_ROWS-1:0] r_row_drive, n_row_drive;
    logic                r_key_valid, n_key_valid;
    t_char               r_key_char, n_key_char;
    logic                r_key_unknown, n_key_unknown;

    logic                    accept;
    logic [KMS_COLS-1:0]     col;
    logic                    all_high;
    logic [KMS_STABLE_W-1:0] stable_inc;
    logic [KMS_STABLE_W-1:0] need;
    logic                    stable_done;
    logic [KMS_ROWS-1:0]     row_bit;
    t_char                   lut_char;
    logic                    lut_unknown;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign col        = i_in.col_levels;
    assign all_high   = (col == COL_ALL_HIGH);

    // Saturating debounce counter; a length of zero acts as one
    assign stable_inc  = (r_stable == STABLE_MAX) ? STABLE_MAX : r_stable + 1'b1;
    assign need        = (r_debounce_len == '0) ? KMS_STABLE_W'(1) : r_debounce_len;
    assign stable_done = (stable_inc >= need);
    assign row_bit     = KMS_ROWS'(1) << r_row;

    kms_key_lookup u_lookup (
        .i_code    (r_code),
        .o_char    (lut_char),
        .o_unknown (lut_unknown)
    );

    // Next state and result for the sample on the input
    always_comb begin
        n_mode        = r_mode;
        n_stable      = r_stable;
        n_row         = r_row;
        n_settle      = r_settle;
        n_code        = r_code;
        n_row_drive   = '0;
        n_key_valid   = 1'b0;
        n_key_char    = '0;
        n_key_unknown = 1'b0;
        case (r_mode)
            MODE_SCAN: begin
                if (r_settle < r_settle_ticks) begin
                    n_settle    = r_settle + 1'b1;
                    n_row_drive = row_bit;
                end else begin
                    if (all_high) begin
                        n_code = r_code | {row_bit, {KMS_COLS{1'b0}}};
                    end
                    n_settle = '0;
                    if (r_row == KMS_ROW_W'(KMS_ROWS - 1)) begin
                        n_row    = '0;
                        n_stable = '0;
                        n_mode   = MODE_RELEASE;
                    end else begin
                        n_row       = r_row + 1'b1;
                        n_row_drive = row_bit << 1;
                    end
                end
            end
            MODE_RELEASE: begin
                if (!all_high) begin
                    n_stable = '0;
                end else if (stable_done) begin
                    n_key_valid   = 1'b1;
                    n_key_char    = lut_char;
                    n_key_unknown = lut_unknown;
                    n_mode        = MODE_IDLE;
                    n_stable      = '0;
                    n_code        = CODE_IDLE;
                end else begin
                    n_stable = stable_inc;
                end
            end
            default: begin
                // Idle, and the unused mode code which behaves as idle
                n_mode = MODE_IDLE;
                if (all_high) begin
                    n_stable = '0;
                end else if (stable_done) begin
                    n_code      = {{KMS_ROWS{1'b0}}, col};
                    n_row       = '0;
                    n_settle    = '0;
                    n_stable    = '0;
                    n_mode      = MODE_SCAN;
                    n_row_drive = KMS_ROWS'(1);
                end else begin
                    n_stable = stable_inc;
                end
            end
        endcase
    end

    // Configuration, scanner state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_RESET;
            r_debounce_len <= DEBOUNCE_RESET;
            r_mode         <= MODE_IDLE;
            r_stable       <= '0;
            r_row          <= '0;
            r_settle       <= '0;
            r_code         <= CODE_IDLE;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_wdata;
                    CFG_DEBOUNCE_LEN: r_debounce_len <= i_cfg_wdata[KMS_STABLE_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_mode      <= n_mode;
                r_stable    <= n_stable;
                r_row       <= n_row;
                r_settle    <= n_settle;
                r_code      <= n_code;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; only loaded with a transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row_drive   <= n_row_drive;
            r_key_valid   <= n_key_valid;
            r_key_char    <= n_key_char;
            r_key_unknown <= n_key_unknown;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.row_drive   = r_row_drive;
    assign o_out.key_valid   = r_key_valid;
    assign o_out.key_char    = r_key_char;
    assign o_out.key_unknown = r_key_unknown;
endmodule

### rtl/kms_checker.sv
// Port-level checks for the keypad scanner, bound to its top level.
// Depends on kms_pkg and keypad_matrix_scanner_unit.
module kms_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [kms_pkg::KMS_ROWS-1:0]  i_row_drive,
    input  logic                          i_key_valid,
    input  logic [7:0]                    i_key_char,
    input  logic                          i_key_unknown
);
    import kms_pkg::*;

    // Nothing is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // At most one row is raised at a time
    a_row_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0(i_row_drive))
        else $error("more than one row driven");

    // A key event comes only after the scan, with all rows low
    a_event_rows_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_key_valid |-> i_row_drive == '0)
        else $error("key event while a row is driven");

    // Unknown key is part of an event and carries no character
    a_unknown_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_key_unknown || !i_key_valid) |->
            i_key_char == 8'h00 && (i_key_valid || !i_key_unknown))
        else $error("character or unknown flag outside a key event");

    // A stalled transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_row_drive) && $stable(i_key_valid)
            && $stable(i_key_char) && $stable(i_key_unknown))
        else $error("stalled output changed");
endmodule

bind keypad_matrix_scanner_unit kms_checker u_kms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_row_drive   (o_out.row_drive),
    .i_key_valid   (o_out.key_valid),
    .i_key_char    (o_out.key_char),
    .i_key_unknown (o_out.key_unknown)
);

### bench/kms_scan_checker.sv
// Checker for the keypad matrix scanner: watches both channels and the config port,
// predicts every output transaction and compares it field by field.
// Depends on kms_pkg, kms_in_if and kms_out_if.
module kms_scan_checker
    import kms_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    kms_in_if                         i_in_ch,
    kms_out_if                        i_out_ch,
    input  logic                      i_cfg_we,
    input  logic [KMS_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [KMS_CFG_DATA_W-1:0] i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef enum logic [1:0] {
        MODE_WAIT_PRESS,
        MODE_ROW_SCAN,
        MODE_WAIT_RELEASE
    } scan_mode_e;

    typedef struct packed {
        logic [KMS_ROWS-1:0] row_drive;
        logic                key_valid;
        t_char               key_char;
        logic                key_unknown;
    } key_event_t;

    // Predictor copy of the registers and scan state
    logic [KMS_SETTLE_W-1:0] settle_reg;
    logic [KMS_STABLE_W-1:0] debounce_reg;
    scan_mode_e              mode;
    logic [KMS_STABLE_W-1:0] stable_cnt;
    logic [KMS_ROW_W-1:0]    row_idx;
    logic [KMS_SETTLE_W-1:0] settle_cnt;
    t_code                   code_reg;

    key_event_t expected_events[$];
    int         fail_count;

    // One more stable sample; a debounce length of zero acts as one
    task automatic count_stable(output logic done);
        logic [KMS_STABLE_W-1:0] need;
        need = (debounce_reg == '0) ? 5'd1 : debounce_reg;
        if (stable_cnt < STABLE_MAX)
            stable_cnt = stable_cnt + 1'b1;
        done = (stable_cnt >= need);
    endtask

    // Next scanner state and output for one column sample
    task automatic predict_tick(input logic [KMS_COLS-1:0] col, output key_event_t ev);
        logic done;
        logic found;
        ev = '0;
        case (mode)
            MODE_ROW_SCAN: begin
                if (settle_cnt < settle_reg) begin
                    settle_cnt = settle_cnt + 1'b1;
                    ev.row_drive = 4'b0001 << row_idx;
                end else begin
                    // the row that brings every column high belongs to the key
                    if (col == COL_ALL_HIGH)
                        code_reg[KMS_COLS + row_idx] = 1'b1;
                    settle_cnt = '0;
                    if (row_idx == KMS_ROW_W'(KMS_ROWS - 1)) begin
                        row_idx = '0;
                        stable_cnt = '0;
                        mode = MODE_WAIT_RELEASE;
                    end else begin
                        row_idx = row_idx + 1'b1;
                        ev.row_drive = 4'b0001 << row_idx;
                    end
                end
            end
            MODE_WAIT_RELEASE: begin
                if (col != COL_ALL_HIGH) begin
                    stable_cnt = '0;
                end else begin
                    count_stable(done);
                    if (done) begin
                        found = 1'b0;
                        ev.key_valid = 1'b1;
                        for (int k = 0; k < KMS_KEYS; k++) begin
                            if (!found && KEY_CODES[k] == code_reg) begin
                                ev.key_char = KEY_CHARS[k];
                                found = 1'b1;
                            end
                        end
                        ev.key_unknown = !found;
                        mode = MODE_WAIT_PRESS;
                        stable_cnt = '0;
                        code_reg = CODE_IDLE;
                    end
                end
            end
            default: begin
                mode = MODE_WAIT_PRESS;
                if (col == COL_ALL_HIGH) begin
                    stable_cnt = '0;
                end else begin
                    count_stable(done);
                    if (done) begin
                        code_reg = {{KMS_ROWS{1'b0}}, col};
                        row_idx = '0;
                        settle_cnt = '0;
                        stable_cnt = '0;
                        mode = MODE_ROW_SCAN;
                        ev.row_drive = 4'b0001;
                    end
                end
            end
        endcase
    endtask

    function automatic bit field_bad(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Compare the oldest expectation first, then queue the new one
    always @(posedge i_clk) begin
        key_event_t want;
        if (!i_rst_n) begin
            settle_reg   = SETTLE_RESET;
            debounce_reg = DEBOUNCE_RESET;
            mode         = MODE_WAIT_PRESS;
            stable_cnt   = '0;
            row_idx      = '0;
            settle_cnt   = '0;
            code_reg     = CODE_IDLE;
            fail_count   = 0;
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SETTLE_TICKS)
                    settle_reg = i_cfg_wdata;
                else if (i_cfg_idx == CFG_DEBOUNCE_LEN)
                    debounce_reg = i_cfg_wdata[KMS_STABLE_W-1:0];
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_events.size() == 0) begin
                    fail_count++;
                    $display("%0t: output transaction with nothing expected: expected none, "
                             , $time, "actual row %h valid %b char %h unknown %b",
                             i_out_ch.row_drive, i_out_ch.key_valid,
                             i_out_ch.key_char, i_out_ch.key_unknown);
                end else begin
                    want = expected_events.pop_front();
                    if (field_bad("row_drive", 8'(want.row_drive), 8'(i_out_ch.row_drive)))
                        fail_count++;
                    if (field_bad("key_valid", 8'(want.key_valid), 8'(i_out_ch.key_valid)))
                        fail_count++;
                    if (field_bad("key_char", want.key_char, i_out_ch.key_char))
                        fail_count++;
                    if (field_bad("key_unknown", 8'(want.key_unknown),
                                  8'(i_out_ch.key_unknown)))
                        fail_count++;
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                predict_tick(i_in_ch.col_levels, want);
                expected_events.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_events.size();
    end

endmodule

### bench/keypad_matrix_scanner_unit_test.sv
// Top of the keypad scanner bench: clock, reset, column sample stimulus with
// random gaps and output stalls, config writes and the verdict.
// Depends on kms_pkg, the channel interfaces, the scanner and kms_scan_checker.
module keypad_matrix_scanner_unit_test;
    import kms_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 300;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [KMS_CFG_IDX_W-1:0]  cfg_idx;
    logic [KMS_CFG_DATA_W-1:0] cfg_wdata;
    int                        fail_count;
    int                        pending;

    bit idling_on;
    int cur_settle;
    int cur_need;
    int items_sent;

    kms_in_if  in_ch();
    kms_out_if out_ch();

    keypad_matrix_scanner_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    kms_scan_checker key_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Output side: ready with random stall bursts
    initial begin : sink_side
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [KMS_COLS-1:0] pressed_level();
        return KMS_COLS'($urandom_range(0, 6));
    endfunction

    function automatic t_code random_code();
        if ($urandom_range(0, 9) < 7)
            return KEY_CODES[$urandom_range(0, KMS_KEYS - 1)];
        return {KMS_ROWS'($urandom), KMS_COLS'($urandom_range(0, 6))};
    endfunction

    // One column sample transaction, with an optional idle gap in front
    task automatic send_sample(input logic [KMS_COLS-1:0] col);
        int gap;
        if (idling_on && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            in_ch.col_levels <= KMS_COLS'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.col_levels <= col;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Stop sending and wait until every result has been taken
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [KMS_CFG_DATA_W-1:0] settle,
                             input logic [KMS_CFG_DATA_W-1:0] deb_word);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_SETTLE_TICKS;
        cfg_wdata <= settle;
        @(posedge clk);
        cfg_idx   <= CFG_DEBOUNCE_LEN;
        cfg_wdata <= deb_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_settle = settle;
        cur_need   = (deb_word[KMS_STABLE_W-1:0] == '0) ? 1 : deb_word[KMS_STABLE_W-1:0];
    endtask

    // Full press: debounce, row scan answers from the code, release debounce
    task automatic press_key(input t_code code, input bit bounce);
        if (bounce && cur_need > 1) begin
            repeat ($urandom_range(1, cur_need - 1)) send_sample(pressed_level());
            send_sample(COL_ALL_HIGH);
        end
        repeat (cur_need - 1) send_sample(pressed_level());
        send_sample(code[KMS_COLS-1:0]);
        for (int r = 0; r < KMS_ROWS; r++) begin
            repeat (cur_settle) send_sample(KMS_COLS'($urandom));
            send_sample(code[KMS_COLS + r] ? COL_ALL_HIGH : pressed_level());
        end
        if (bounce && cur_need > 1) begin
            repeat ($urandom_range(1, cur_need - 1)) send_sample(COL_ALL_HIGH);
            send_sample(pressed_level());
        end
        repeat (cur_need) send_sample(COL_ALL_HIGH);
    endtask

    // Random levels, then enough released samples to get back to idle
    task automatic send_noise();
        repeat ($urandom_range(1, 12)) send_sample(KMS_COLS'($urandom));
        repeat (4 * (cur_settle + 1) + cur_need) send_sample(COL_ALL_HIGH);
    endtask

    initial begin : stimulus
        int phase;
        int sel;
        in_ch.valid      <= 1'b0;
        in_ch.col_levels <= COL_ALL_HIGH;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_SETTLE_TICKS;
        cfg_wdata        <= '0;
        rst_n            <= 1'b0;
        idling_on  = 1'b1;
        cur_settle = SETTLE_RESET;
        cur_need   = DEBOUNCE_RESET;
        items_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Settings out of reset
        press_key(KEY_CODES[5], 1'b0);
        drain_results();

        // Directed: zero debounce and zero settle, then the edge cases
        configure(16'd0, 16'd0);
        send_sample(COL_ALL_HIGH);
        press_key(KEY_CODES[1], 1'b0);
        press_key(KEY_CODES[KMS_KEYS - 1], 1'b0);
        press_key({4'b1111, 3'b011}, 1'b0);   // every row reads high
        press_key({4'b0000, 3'b000}, 1'b0);   // no row reads high

        // Random phases with short settings
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            drain_results();
            case (phase % 8)
                0: configure(16'd0, {11'($urandom), 5'd0});
                1: configure(16'd0, 16'd1);
                2: configure(16'd1, 16'd16);
                3: configure(16'd2, {11'($urandom), 5'd31});
                4: configure(16'd3, 16'd2);
                default: configure(16'($urandom_range(0, 3)),
                                   {11'($urandom), 5'($urandom_range(1, 16))});
            endcase
            idling_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8)) begin
                sel = $urandom_range(0, 9);
                if (sel < 2)
                    send_noise();
                else
                    press_key(random_code(), sel < 4);
            end
            phase++;
        end

        // Last part without idling: default timing, then the widest debounce word
        idling_on = 1'b0;
        drain_results();
        configure(SETTLE_RESET, DEBOUNCE_RESET);
        press_key(random_code(), 1'b1);
        drain_results();
        configure(16'd1, 16'hFFFF);
        press_key(KEY_CODES[0], 1'b0);
        drain_results();

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
